// ===== sv/usmg_pkg.sv =====
// Shared types, section codes and the trig series used to build the sphere tables.
package usmg_pkg;

    // Section codes of the mesh sequencer
    localparam logic [2:0] SEC_TOP_V   = 3'd0;
    localparam logic [2:0] SEC_RING_V  = 3'd1;
    localparam logic [2:0] SEC_BOT_V   = 3'd2;
    localparam logic [2:0] SEC_TOP_FAN = 3'd3;
    localparam logic [2:0] SEC_MID     = 3'd4;
    localparam logic [2:0] SEC_BOT_FAN = 3'd5;
    localparam logic [2:0] SEC_DONE    = 3'd6;

    // Field widths
    localparam int CNT_W  = 7;
    localparam int POS_W  = 16;
    localparam int TEX_W  = 15;
    localparam int IDX_W  = 13;
    localparam int DATA_W = 120;

    // Q2.14 and Q30 constants
    localparam logic signed [POS_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic [TEX_W-1:0]        TEX_ONE     = 15'd16384;
    localparam longint unsigned         Q30_ONE     = 64'd1073741824;
    localparam longint unsigned         HALF_PI_Q30 = 64'd1686629713;

    // One mesh item as it leaves the sequencer
    typedef struct packed {
        logic [2:0]       sec;
        logic [CNT_W-1:0] ring;
        logic [CNT_W-1:0] col;
        logic             half;
        logic             ccw;
        logic             last;
    } desc_t;

    // Taylor series in Q30 for x in [0, pi/2): sin if odd, else cos; result Q2.14
    function automatic int series_q14(input longint unsigned x, input logic odd);
        longint unsigned t;
        longint          sum;
        t   = odd ? x : Q30_ONE;
        sum = longint'(t);
        for (int k = 1; k <= 7; k++) begin
            t = (((t * x) >> 30) * x) >> 30;
            case (k)
                1:       t = odd ? t / 6   : t / 2;
                2:       t = odd ? t / 20  : t / 12;
                3:       t = odd ? t / 42  : t / 30;
                4:       t = odd ? t / 72  : t / 56;
                5:       t = odd ? t / 110 : t / 90;
                6:       t = odd ? t / 156 : t / 132;
                default: t = odd ? t / 210 : t / 182;
            endcase
            if ((k & 1) != 0)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum <= 0)
            return 0;
        sum = (sum + 64'sd32768) >>> 16;
        if (sum > 64'sd16384)
            return 16384;
        return int'(sum);
    endfunction

endpackage

// ===== sv/uv_sphere_mesh_generator.sv =====
// UV sphere mesh generator top level.
// Each item taken on the s_ channel is a tick: s_tdata[0] = restart. A tick
// with restart low asks for the next mesh item; restart high abandons the
// current mesh and yields the top pole. The m_ channel carries one result
// per tick until the mesh is finished: vertices first (top pole, RINGS-1
// rings of SEGMENTS+1 vertices, bottom pole), then triangles (top fan,
// middle band quads as two triangles, bottom fan). m_tuser is high for a
// vertex, m_tlast marks the final triangle. Ticks after the final triangle
// give no result until a restart.
// A result reaches m_ once its tick has passed the sequencer register, then
// the output register. Throughput: one item per cycle while m_tready is high,
// set by the counter update in the sequencer.
// Reset puts the sequencer at the top pole, empties both registers and sets
// front_ccw to 1. cfg_we/cfg_wdata write front_ccw; write it only when idle.
// When m_tready is low the output holds; s_tready then falls once both the
// sequencer register and the output register hold items.
module uv_sphere_mesh_generator #(
    parameter int RINGS    = 10,  // 3..64
    parameter int SEGMENTS = 10   // 3..64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,   // front_ccw
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,     // [0] restart, [7:1] zero
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [62:48] tex_u, [77:63] tex_v,
    // [90:78] corner_a, [103:91] corner_b, [116:104] corner_c, [119:117] zero
    output logic [usmg_pkg::DATA_W-1:0]  m_tdata,
    output logic                         m_tuser,     // [0] is_vertex
    output logic                         m_tlast      // mesh_end
);

    usmg_pkg::desc_t desc;
    logic            desc_valid;
    logic            out_adv;
    logic            seq_adv;

    // Sequencer register loads when empty or when the output stage takes it
    assign seq_adv  = !desc_valid || out_adv;
    assign s_tready = seq_adv;

    usmg_seq #(
        .RINGS    (RINGS),
        .SEGMENTS (SEGMENTS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .take       (s_tvalid && seq_adv),
        .advance    (seq_adv),
        .restart    (s_tdata[0]),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    usmg_emit #(
        .RINGS    (RINGS),
        .SEGMENTS (SEGMENTS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .out_ready  (m_tready),
        .advance    (out_adv),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata),
        .out_vertex (m_tuser),
        .out_last   (m_tlast)
    );

endmodule

// ===== sv/usmg_trig_rom.sv =====
// Constant sine, cosine and texture-ratio table indexed by ring or column.
module usmg_trig_rom #(
    parameter int DIV     = 10,   // entries per full turn
    parameter int TEX_DEN = 10,   // texture coordinate denominator
    parameter int DEPTH   = 11    // valid entries
) (
    input  logic [$clog2(DEPTH)-1:0]           idx,
    output logic signed [usmg_pkg::POS_W-1:0]  sin_q,
    output logic signed [usmg_pkg::POS_W-1:0]  cos_q,
    output logic [usmg_pkg::TEX_W-1:0]         tex_q
);

    localparam int AW   = $clog2(DEPTH);
    localparam int ENTS = 2 ** AW;

    logic signed [usmg_pkg::POS_W-1:0] sin_tab [ENTS];
    logic signed [usmg_pkg::POS_W-1:0] cos_tab [ENTS];
    logic [usmg_pkg::TEX_W-1:0]        tex_tab [ENTS];

    // Table entries worked out at elaboration
    for (genvar k = 0; k < ENTS; k++) begin : g_ent
        localparam longint unsigned NS = longint'(k) * 64'd4;
        localparam longint unsigned NC = NS + longint'(DIV);
        localparam longint unsigned QS = (NS / DIV) & 64'd3;
        localparam longint unsigned QC = (NC / DIV) & 64'd3;
        localparam longint unsigned XS = ((NS % DIV) * usmg_pkg::HALF_PI_Q30) / DIV;
        localparam longint unsigned XC = ((NC % DIV) * usmg_pkg::HALF_PI_Q30) / DIV;
        localparam int VS = usmg_pkg::series_q14(XS, (QS & 64'd1) == 64'd0);
        localparam int VC = usmg_pkg::series_q14(XC, (QC & 64'd1) == 64'd0);
        localparam logic signed [usmg_pkg::POS_W-1:0] SIN_V =
            (QS >= 64'd2) ? 16'(-VS) : 16'(VS);
        localparam logic signed [usmg_pkg::POS_W-1:0] COS_V =
            (QC >= 64'd2) ? 16'(-VC) : 16'(VC);
        localparam longint unsigned TX = (longint'(k) * 64'd16384 + TEX_DEN / 2) / TEX_DEN;

        assign sin_tab[k] = (k < DEPTH) ? SIN_V : '0;
        assign cos_tab[k] = (k < DEPTH) ? COS_V : '0;
        assign tex_tab[k] = (k < DEPTH) ? TX[usmg_pkg::TEX_W-1:0] : '0;
    end

    // Lookup
    assign sin_q = sin_tab[idx];
    assign cos_q = cos_tab[idx];
    assign tex_q = tex_tab[idx];

endmodule

// ===== sv/usmg_seq.sv =====
// Mesh sequencer: section/ring/column counters, winding register and item register.
module usmg_seq #(
    parameter int RINGS    = 10,
    parameter int SEGMENTS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              take,      // input item accepted this cycle
    input  logic              advance,   // item register may load
    input  logic              restart,
    output logic              desc_valid,
    output usmg_pkg::desc_t   desc
);

    localparam logic [usmg_pkg::CNT_W-1:0] SEG_C   = usmg_pkg::CNT_W'(SEGMENTS);
    localparam logic [usmg_pkg::CNT_W-1:0] RLAST_C = usmg_pkg::CNT_W'(RINGS - 1);
    localparam logic [usmg_pkg::CNT_W-1:0] RMID_C  = usmg_pkg::CNT_W'(RINGS - 2);
    localparam logic [usmg_pkg::CNT_W-1:0] ONE_C   = usmg_pkg::CNT_W'(1);

    logic [2:0]                 sec_reg, sec_next;
    logic [usmg_pkg::CNT_W-1:0] ring_reg, ring_next;
    logic [usmg_pkg::CNT_W-1:0] col_reg, col_next;
    logic                       half_reg, half_next;
    logic                       ccw_reg;
    logic                       valid_reg, valid_next;
    usmg_pkg::desc_t            desc_reg, desc_next;

    logic [2:0]                 sec_eff;
    logic [usmg_pkg::CNT_W-1:0] ring_eff, col_eff, col_inc, ring_inc;
    logic                       half_eff, emit;

    // Winding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ccw_reg <= 1'b1;
        else if (cfg_we)
            ccw_reg <= cfg_wdata;
    end

    // Next state and item descriptor
    always_comb
    begin
        sec_eff  = restart ? usmg_pkg::SEC_TOP_V : sec_reg;
        ring_eff = restart ? '0 : ring_reg;
        col_eff  = restart ? '0 : col_reg;
        half_eff = restart ? 1'b0 : half_reg;
        col_inc  = col_eff + ONE_C;
        ring_inc = ring_eff + ONE_C;

        sec_next  = sec_eff;
        ring_next = ring_eff;
        col_next  = col_eff;
        half_next = half_eff;
        emit      = 1'b1;

        desc_next.sec  = sec_eff;
        desc_next.ring = ring_eff;
        desc_next.col  = col_eff;
        desc_next.half = half_eff;
        desc_next.ccw  = ccw_reg;
        desc_next.last = 1'b0;

        case (sec_eff)
            usmg_pkg::SEC_TOP_V:
            begin
                sec_next  = usmg_pkg::SEC_RING_V;
                ring_next = ONE_C;
                col_next  = '0;
            end
            usmg_pkg::SEC_RING_V:
            begin
                if (col_eff >= SEG_C)
                begin
                    col_next  = '0;
                    ring_next = ring_inc;
                    if (ring_eff >= RLAST_C)
                        sec_next = usmg_pkg::SEC_BOT_V;
                end
                else
                    col_next = col_inc;
            end
            usmg_pkg::SEC_BOT_V:
            begin
                sec_next = usmg_pkg::SEC_TOP_FAN;
                col_next = '0;
            end
            usmg_pkg::SEC_TOP_FAN:
            begin
                col_next = col_inc;
                if (col_inc >= SEG_C)
                begin
                    sec_next  = usmg_pkg::SEC_MID;
                    ring_next = '0;
                    col_next  = '0;
                    half_next = 1'b0;
                end
            end
            usmg_pkg::SEC_MID:
            begin
                if (!half_eff)
                    half_next = 1'b1;
                else
                begin
                    half_next = 1'b0;
                    col_next  = col_inc;
                    if (col_inc >= SEG_C)
                    begin
                        col_next  = '0;
                        ring_next = ring_inc;
                        if (ring_inc >= RMID_C)
                            sec_next = usmg_pkg::SEC_BOT_FAN;
                    end
                end
            end
            usmg_pkg::SEC_BOT_FAN:
            begin
                desc_next.last = (col_inc >= SEG_C);
                col_next       = col_inc;
                if (col_inc >= SEG_C)
                    sec_next = usmg_pkg::SEC_DONE;
            end
            default:
                emit = 1'b0;
        endcase

        valid_next = take & emit;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg  <= usmg_pkg::SEC_TOP_V;
            ring_reg <= '0;
            col_reg  <= '0;
            half_reg <= 1'b0;
        end
        else if (take)
        begin
            sec_reg  <= sec_next;
            ring_reg <= ring_next;
            col_reg  <= col_next;
            half_reg <= half_next;
        end
    end

    // Item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && take)
            desc_reg <= desc_next;
    end

    assign desc_valid = valid_reg;
    assign desc       = desc_reg;

endmodule

// ===== sv/usmg_emit.sv =====
// Result stage: table lookups, position products, vertex indices and output register.
module usmg_emit #(
    parameter int RINGS    = 10,
    parameter int SEGMENTS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          desc_valid,
    input  usmg_pkg::desc_t               desc,
    input  logic                          out_ready,
    output logic                          advance,   // output register may load
    output logic                          out_valid,
    output logic [usmg_pkg::DATA_W-1:0]   out_data,
    output logic                          out_vertex,
    output logic                          out_last
);

    localparam int RAW = $clog2(RINGS);
    localparam int CAW = $clog2(SEGMENTS + 1);
    localparam logic [usmg_pkg::IDX_W-1:0] RV_C    = usmg_pkg::IDX_W'(SEGMENTS + 1);
    localparam logic [usmg_pkg::IDX_W-1:0] SOUTH_C =
        usmg_pkg::IDX_W'(1 + (RINGS - 1) * (SEGMENTS + 1));
    localparam logic [usmg_pkg::IDX_W-1:0] IONE    = usmg_pkg::IDX_W'(1);

    logic signed [usmg_pkg::POS_W-1:0] sp, cp, st, ct;
    logic [usmg_pkg::TEX_W-1:0]        tu, tv;

    logic signed [31:0] px, pz;
    logic [usmg_pkg::POS_W-1:0]        rx, rz;

    logic [usmg_pkg::IDX_W-1:0] ring_i, col_i, ia, ib, base;
    logic [usmg_pkg::IDX_W-1:0] ca, cb, cc;
    logic signed [usmg_pkg::POS_W-1:0] x_n, y_n, z_n;
    logic [usmg_pkg::TEX_W-1:0]        u_n, v_n;
    logic                              vtx_n, last_n;

    logic                              valid_reg;
    logic [usmg_pkg::DATA_W-1:0]       data_reg;
    logic                              vtx_reg, last_reg;

    // Ring table: polar angle ring/(2*RINGS) of a turn
    usmg_trig_rom #(
        .DIV     (2 * RINGS),
        .TEX_DEN (RINGS),
        .DEPTH   (RINGS)
    ) u_ring_rom (
        .idx   (desc.ring[RAW-1:0]),
        .sin_q (sp),
        .cos_q (cp),
        .tex_q (tv)
    );

    // Column table: azimuth column/SEGMENTS of a turn
    usmg_trig_rom #(
        .DIV     (SEGMENTS),
        .TEX_DEN (SEGMENTS),
        .DEPTH   (SEGMENTS + 1)
    ) u_col_rom (
        .idx   (desc.col[CAW-1:0]),
        .sin_q (st),
        .cos_q (ct),
        .tex_q (tu)
    );

    // Q2.14 product, rounded to nearest with ties away from zero
    function automatic logic [usmg_pkg::POS_W-1:0] round_q14(input logic signed [31:0] p);
        logic [31:0] mag;
        logic [31:0] rnd;
        logic [usmg_pkg::POS_W-1:0] m16;
        mag = p[31] ? 32'(-p) : 32'(p);
        rnd = (mag + 32'd8192) >> 14;
        m16 = rnd[usmg_pkg::POS_W-1:0];
        return p[31] ? 16'(-m16) : m16;
    endfunction

    assign px = sp * ct;
    assign pz = sp * st;
    assign rx = round_q14(px);
    assign rz = round_q14(pz);

    // Vertex index arithmetic
    assign ring_i = usmg_pkg::IDX_W'(desc.ring);
    assign col_i  = usmg_pkg::IDX_W'(desc.col);
    assign ia     = IONE + ring_i * RV_C + col_i;
    assign ib     = ia + RV_C;
    assign base   = SOUTH_C - RV_C + col_i;

    // Result fields per section
    always_comb
    begin
        vtx_n  = 1'b0;
        last_n = 1'b0;
        x_n    = '0;
        y_n    = '0;
        z_n    = '0;
        u_n    = '0;
        v_n    = '0;
        ca     = '0;
        cb     = '0;
        cc     = '0;
        case (desc.sec)
            usmg_pkg::SEC_TOP_V:
            begin
                vtx_n = 1'b1;
                y_n   = usmg_pkg::ONE_Q14;
            end
            usmg_pkg::SEC_RING_V:
            begin
                vtx_n = 1'b1;
                x_n   = rx;
                y_n   = cp;
                z_n   = rz;
                u_n   = tu;
                v_n   = tv;
            end
            usmg_pkg::SEC_BOT_V:
            begin
                vtx_n = 1'b1;
                y_n   = -usmg_pkg::ONE_Q14;
                v_n   = usmg_pkg::TEX_ONE;
            end
            usmg_pkg::SEC_TOP_FAN:
            begin
                cb = desc.ccw ? col_i + IONE : col_i + 13'd2;
                cc = desc.ccw ? col_i + 13'd2 : col_i + IONE;
            end
            usmg_pkg::SEC_MID:
            begin
                if (!desc.half)
                begin
                    ca = ia;
                    cb = desc.ccw ? ib : ia + IONE;
                    cc = desc.ccw ? ia + IONE : ib;
                end
                else
                begin
                    ca = ib;
                    cb = desc.ccw ? ib + IONE : ia + IONE;
                    cc = desc.ccw ? ia + IONE : ib + IONE;
                end
            end
            usmg_pkg::SEC_BOT_FAN:
            begin
                ca     = SOUTH_C;
                cb     = desc.ccw ? base + IONE : base;
                cc     = desc.ccw ? base : base + IONE;
                last_n = desc.last;
            end
            default:
            begin
                vtx_n = 1'b0;
            end
        endcase
    end

    assign advance = !valid_reg || out_ready;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= desc_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && desc_valid)
        begin
            data_reg <= {3'b000, cc, cb, ca, v_n, u_n, z_n, y_n, x_n};
            vtx_reg  <= vtx_n;
            last_reg <= last_n;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_vertex = vtx_reg;
    assign out_last   = last_reg;

endmodule

// ===== sim/usmg_mesh_checker.sv =====
// Checker for the UV sphere mesh generator: predicts each mesh item and compares the output stream.
`timescale 1ns / 1ps

module usmg_mesh_checker #(
    parameter int RINGS    = 10,
    parameter int SEGMENTS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [usmg_pkg::DATA_W-1:0] m_tdata,
    input  logic                        m_tuser,
    input  logic                        m_tlast,
    output int                          pending,
    output int                          predicted,
    output int                          failures,
    output int                          vertices_seen,
    output int                          tris_ccw,
    output int                          tris_cw,
    output int                          meshes_done,
    output int                          ignored_ticks
);

    typedef struct packed {
        logic                              is_vertex;
        logic signed [usmg_pkg::POS_W-1:0] pos_x;
        logic signed [usmg_pkg::POS_W-1:0] pos_y;
        logic signed [usmg_pkg::POS_W-1:0] pos_z;
        logic [usmg_pkg::TEX_W-1:0]        tex_u;
        logic [usmg_pkg::TEX_W-1:0]        tex_v;
        logic [usmg_pkg::IDX_W-1:0]        corner_a;
        logic [usmg_pkg::IDX_W-1:0]        corner_b;
        logic [usmg_pkg::IDX_W-1:0]        corner_c;
        logic                              mesh_end;
    } mesh_item_t;

    localparam int RING_VERTS = SEGMENTS + 1;
    localparam int SOUTH_IDX  = 1 + (RINGS - 1) * RING_VERTS;

    // Mirror of the sequencer and the winding register
    logic [2:0] section_q;
    int         ring_idx;
    int         col_idx;
    bit         second_tri;
    bit         wind_ccw;

    mesh_item_t mesh_items_due[$];
    mesh_item_t due_item;
    mesh_item_t next_item;
    bit         has_item;

    // Taylor series in Q30, sine terms when odd_series, cosine otherwise; Q2.14 out
    function automatic int taylor_q14(input longint unsigned x, input bit odd_series);
        longint unsigned term;
        longint          acc;
        int              order;
        term  = odd_series ? x : usmg_pkg::Q30_ONE;
        order = odd_series ? 1 : 0;
        acc   = longint'(term);
        for (int k = 1; k <= 7; k++)
        begin
            term  = (((term * x) >> 30) * x) >> 30;
            term  = term / longint'((order + 1) * (order + 2));
            order = order + 2;
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc <= 0)
            return 0;
        acc = (acc + 32768) >>> 16;
        return (acc > 16384) ? 16384 : int'(acc);
    endfunction

    // sin or cos of the angle k/m of a full turn, folded into the first quadrant
    function automatic int trig_q14(input int k, input int m, input bit want_cos);
        longint unsigned turns;
        longint unsigned rem;
        longint unsigned x;
        int              quad;
        int              mag;
        turns = longint'(k) * 4 + (want_cos ? m : 0);
        quad  = int'((turns / m) & 3);
        rem   = turns % m;
        x     = (rem * usmg_pkg::HALF_PI_Q30) / m;
        mag   = taylor_q14(x, quad % 2 == 0);
        return (quad >= 2) ? -mag : mag;
    endfunction

    // Q2.14 product, rounded to nearest with ties away from zero
    function automatic int scale_product(input int a, input int b);
        longint prod;
        longint mag;
        prod = longint'(a) * longint'(b);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 8192) >>> 14;
        return int'((prod < 0) ? -mag : mag);
    endfunction

    function automatic int tex_fraction(input int num, input int den);
        return (num * 16384 + den / 2) / den;
    endfunction

    function automatic mesh_item_t vertex_item(input int x, input int y, input int z,
                                               input int u, input int v);
        mesh_item_t it;
        it           = '0;
        it.is_vertex = 1'b1;
        it.pos_x     = x[usmg_pkg::POS_W-1:0];
        it.pos_y     = y[usmg_pkg::POS_W-1:0];
        it.pos_z     = z[usmg_pkg::POS_W-1:0];
        it.tex_u     = u[usmg_pkg::TEX_W-1:0];
        it.tex_v     = v[usmg_pkg::TEX_W-1:0];
        return it;
    endfunction

    function automatic mesh_item_t tri_item(input int a, input int b, input int c,
                                            input bit last);
        mesh_item_t it;
        it          = '0;
        it.corner_a = a[usmg_pkg::IDX_W-1:0];
        it.corner_b = b[usmg_pkg::IDX_W-1:0];
        it.corner_c = c[usmg_pkg::IDX_W-1:0];
        it.mesh_end = last;
        return it;
    endfunction

    // One tick of the mesh sequence
    task automatic advance_mesh(input logic restart, output bit produced,
                                output mesh_item_t it);
        int sp;
        int cp;
        int st;
        int ct;
        int a;
        int b;
        int base;
        bit last;
        produced = 1'b1;
        it       = '0;
        if (restart)
        begin
            section_q  = usmg_pkg::SEC_TOP_V;
            ring_idx   = 0;
            col_idx    = 0;
            second_tri = 1'b0;
        end
        case (section_q)
            usmg_pkg::SEC_TOP_V:
            begin
                it        = vertex_item(0, 16384, 0, 0, 0);
                section_q = usmg_pkg::SEC_RING_V;
                ring_idx  = 1;
                col_idx   = 0;
            end
            usmg_pkg::SEC_RING_V:
            begin
                sp = trig_q14(ring_idx, 2 * RINGS, 1'b0);
                cp = trig_q14(ring_idx, 2 * RINGS, 1'b1);
                st = trig_q14(col_idx, SEGMENTS, 1'b0);
                ct = trig_q14(col_idx, SEGMENTS, 1'b1);
                it = vertex_item(scale_product(sp, ct), cp, scale_product(sp, st),
                                 tex_fraction(col_idx, SEGMENTS),
                                 tex_fraction(ring_idx, RINGS));
                col_idx++;
                if (col_idx > SEGMENTS)
                begin
                    col_idx = 0;
                    ring_idx++;
                    if (ring_idx > RINGS - 1)
                        section_q = usmg_pkg::SEC_BOT_V;
                end
            end
            usmg_pkg::SEC_BOT_V:
            begin
                it        = vertex_item(0, -16384, 0, 0, 16384);
                section_q = usmg_pkg::SEC_TOP_FAN;
                col_idx   = 0;
            end
            usmg_pkg::SEC_TOP_FAN:
            begin
                a  = col_idx + 1;
                it = wind_ccw ? tri_item(0, a, a + 1, 1'b0) : tri_item(0, a + 1, a, 1'b0);
                col_idx++;
                if (col_idx >= SEGMENTS)
                begin
                    section_q  = usmg_pkg::SEC_MID;
                    ring_idx   = 0;
                    col_idx    = 0;
                    second_tri = 1'b0;
                end
            end
            usmg_pkg::SEC_MID:
            begin
                a = 1 + ring_idx * RING_VERTS + col_idx;
                b = a + RING_VERTS;
                if (!second_tri)
                begin
                    it = wind_ccw ? tri_item(a, b, a + 1, 1'b0)
                                  : tri_item(a, a + 1, b, 1'b0);
                    second_tri = 1'b1;
                end
                else
                begin
                    it = wind_ccw ? tri_item(b, b + 1, a + 1, 1'b0)
                                  : tri_item(b, a + 1, b + 1, 1'b0);
                    second_tri = 1'b0;
                    col_idx++;
                    if (col_idx >= SEGMENTS)
                    begin
                        col_idx = 0;
                        ring_idx++;
                        if (ring_idx >= RINGS - 2)
                            section_q = usmg_pkg::SEC_BOT_FAN;
                    end
                end
            end
            usmg_pkg::SEC_BOT_FAN:
            begin
                base = SOUTH_IDX - RING_VERTS + col_idx;
                last = (col_idx + 1 >= SEGMENTS);
                it   = wind_ccw ? tri_item(SOUTH_IDX, base + 1, base, last)
                                : tri_item(SOUTH_IDX, base, base + 1, last);
                col_idx++;
                if (last)
                    section_q = usmg_pkg::SEC_DONE;
            end
            default:
            begin
                // finished mesh: tick is swallowed
                produced = 1'b0;
            end
        endcase
        if (produced && it.is_vertex)
            vertices_seen++;
        else if (produced && wind_ccw)
            tris_ccw++;
        else if (produced)
            tris_cw++;
        if (produced && it.mesh_end)
            meshes_done++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Scoreboard: compare outputs against the oldest prediction, then predict new ticks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_q     = usmg_pkg::SEC_TOP_V;
            ring_idx      = 0;
            col_idx       = 0;
            second_tri    = 1'b0;
            wind_ccw      = 1'b1;
            mesh_items_due.delete();
            failures      = 0;
            vertices_seen = 0;
            tris_ccw      = 0;
            tris_cw       = 0;
            meshes_done   = 0;
            ignored_ticks = 0;
            pending       <= 0;
            predicted     <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (mesh_items_due.size() == 0)
                begin
                    $error("output item with no prediction waiting");
                    failures++;
                end
                else
                begin
                    due_item = mesh_items_due.pop_front();
                    check_field("is_vertex", int'(due_item.is_vertex), int'(m_tuser));
                    check_field("pos_x", int'(due_item.pos_x),
                                int'($signed(m_tdata[15:0])));
                    check_field("pos_y", int'(due_item.pos_y),
                                int'($signed(m_tdata[31:16])));
                    check_field("pos_z", int'(due_item.pos_z),
                                int'($signed(m_tdata[47:32])));
                    check_field("tex_u", int'(due_item.tex_u), int'(m_tdata[62:48]));
                    check_field("tex_v", int'(due_item.tex_v), int'(m_tdata[77:63]));
                    check_field("corner_a", int'(due_item.corner_a), int'(m_tdata[90:78]));
                    check_field("corner_b", int'(due_item.corner_b), int'(m_tdata[103:91]));
                    check_field("corner_c", int'(due_item.corner_c),
                                int'(m_tdata[116:104]));
                    check_field("mesh_end", int'(due_item.mesh_end), int'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_mesh(s_tdata[0], has_item, next_item);
                if (has_item)
                begin
                    mesh_items_due = {mesh_items_due, next_item};
                    predicted <= predicted + 1;
                end
                else
                    ignored_ticks++;
            end
            if (cfg_we)
                wind_ccw = cfg_wdata;
            pending <= mesh_items_due.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the UV sphere mesh generator: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int RINGS          = 10;
    localparam int SEGMENTS       = 10;
    localparam int MESH_ITEMS     = (RINGS - 1) * (SEGMENTS + 1) + 2
                                    + 2 * SEGMENTS * (RINGS - 1);
    localparam int OPENING_TICKS  = 20;
    localparam int TOTAL_TICKS    = 950;
    localparam int SETTLE_CYCLES  = 6;
    localparam int BACKLOG_CYCLES = 250;
    localparam int BACKLOG_AT     = OPENING_TICKS + 1;
    localparam int STALL_LIMIT    = 3000;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic                        cfg_wdata = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata   = 8'd0;   // [0] restart
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [usmg_pkg::DATA_W-1:0] m_tdata;            // pos_x .. corner_c, see dut
    logic                        m_tuser;            // [0] is_vertex
    logic                        m_tlast;            // mesh_end

    int pending;
    int predicted;
    int failures;
    int vertices_seen;
    int tris_ccw;
    int tris_cw;
    int meshes_done;
    int ignored_ticks;

    int ticks_sent    = 0;
    int restarts_sent = 0;
    int stuck_cycles  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    uv_sphere_mesh_generator #(
        .RINGS    (RINGS),
        .SEGMENTS (SEGMENTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    usmg_mesh_checker #(
        .RINGS    (RINGS),
        .SEGMENTS (SEGMENTS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .pending       (pending),
        .predicted     (predicted),
        .failures      (failures),
        .vertices_seen (vertices_seen),
        .tris_ccw      (tris_ccw),
        .tris_cw       (tris_cw),
        .meshes_done   (meshes_done),
        .ignored_ticks (ignored_ticks)
    );

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_tick(input bit restart, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // Wait until every predicted item has come out and the pipeline has drained
    task automatic settle();
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_winding(input bit ccw_sel);
        cfg_we    <= 1'b1;
        cfg_wdata <= ccw_sel;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: random back-pressure, one long hold-off to fill the block
    initial
    begin : receiver
        int  gap;
        bit  backlog_done;
        backlog_done = 1'b0;
        forever
        begin
            if (!backlog_done && ticks_sent >= BACKLOG_AT)
            begin
                backlog_done = 1'b1;
                gap          = BACKLOG_CYCLES;
            end
            else
                gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(30, 80)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Watchdog on cycles where no item moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    // Stimulus
    initial
    begin : stimulus
        int phase;
        int run_len;
        bit no_gaps;
        bit wind_sel;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening: first tick from reset without restart, restarts mid-mesh and back to back
        for (int i = 0; i < OPENING_TICKS; i++)
            send_tick(i == 3 || i == 6 || i == 7 || i == 15, i >= 10);
        s_tvalid <= 1'b0;

        // One whole mesh back to back; the receiver's long hold-off falls inside it
        settle();
        for (int i = 0; i < MESH_ITEMS; i++)
            send_tick(i == 0, 1'b1);
        s_tvalid <= 1'b0;

        // Random phases: long runs with rare restarts, winding changed while idle
        phase = 0;
        while (ticks_sent < TOTAL_TICKS)
        begin
            settle();
            if (phase < 2)
                wind_sel = (phase == 1);
            else
                wind_sel = ($urandom_range(0, 1) == 1);
            write_winding(wind_sel);
            no_gaps = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(60, 220);
            if (run_len > TOTAL_TICKS - ticks_sent)
                run_len = TOTAL_TICKS - ticks_sent;
            for (int i = 0; i < run_len; i++)
            begin
                if (i == 0)
                    send_tick(phase < 2 || $urandom_range(0, 1) == 1, no_gaps);
                else
                    send_tick($urandom_range(0, 299) == 0, no_gaps);
            end
            s_tvalid <= 1'b0;
            phase++;
        end

        settle();
        $display("Run covered %0d vertices, %0d ccw and %0d cw triangles, %0d complete meshes",
                 vertices_seen, tris_ccw, tris_cw, meshes_done);
        $display("%0d ticks sent with %0d restarts, %0d items; %0d ticks swallowed",
                 ticks_sent, restarts_sent, predicted, ignored_ticks);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
